// ===== hdl/host_bridge_config_space_macros.svh =====
// Assertion macros shared by the host bridge configuration space checkers.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef HOST_BRIDGE_CONFIG_SPACE_MACROS_SVH
`define HOST_BRIDGE_CONFIG_SPACE_MACROS_SVH

// check outside of reset
`define HBCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define HBCS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hbcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the host bridge configuration space.
// No dependencies.
package hbcs_pkg;

   localparam int CONFIG_DEPTH = 256;
   localparam int ADDR_W       = 8;

   typedef enum logic [1:0] {
      OP_CFG_RD  = 2'd0,
      OP_CFG_WR  = 2'd1,
      OP_PORT_RD = 2'd2,
      OP_PORT_WR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RST_NONE = 2'd0,
      RST_HARD = 2'd1,
      RST_SOFT = 2'd2
   } reset_kind_type;

   localparam logic [ADDR_W-1:0] ADDR_CMD_LO = 8'h04;
   localparam logic [ADDR_W-1:0] ADDR_CMD_HI = 8'h05;
   localparam logic [ADDR_W-1:0] ADDR_STS_LO = 8'h06;
   localparam logic [ADDR_W-1:0] ADDR_STS_HI = 8'h07;
   localparam logic [ADDR_W-1:0] ADDR_PAM0   = 8'h59;
   localparam logic [ADDR_W-1:0] ADDR_PAM1   = 8'h5A;
   localparam logic [ADDR_W-1:0] ADDR_PAM6   = 8'h5F;
   localparam logic [ADDR_W-1:0] ADDR_SMRAM  = 8'h72;

   localparam logic [19:0] BASE_PAM0  = 20'hF0000;
   localparam logic [19:0] BASE_PAM1  = 20'hC0000;
   localparam logic [19:0] BASE_SMRAM = 20'hA0000;
   localparam logic [19:0] PAM_HALF   = 20'h04000;
   localparam logic [17:0] SIZE_PAM0  = 18'h10000;
   localparam logic [17:0] SIZE_PAM   = 18'h04000;
   localparam logic [17:0] SIZE_SMRAM = 18'h20000;

   localparam logic [7:0] PAM0_HARD_RESET = 8'h0F;

   typedef struct packed {
      logic [7:0]     rdata;
      logic           map_valid;
      logic [19:0]    map_base;
      logic [17:0]    map_size;
      logic           read_internal;
      logic           write_internal;
      reset_kind_type reset_kind;
      logic           last;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              clr_smram;
   } wr_type;

   function automatic logic [7:0] reset_value(input logic [ADDR_W-1:0] addr);
      logic [7:0] val;
      unique case (addr)
         8'h00: val = 8'h86;
         8'h01: val = 8'h80;
         8'h02: val = 8'hA3;
         8'h03: val = 8'h04;
         8'h04: val = 8'h06;
         8'h07: val = 8'h02;
         8'h08: val = 8'h03;
         8'h0B: val = 8'h06;
         8'h50: val = 8'h80;
         8'h52: val = 8'h40;
         8'h57: val = 8'h31;
         8'h60, 8'h61, 8'h62, 8'h63, 8'h64: val = 8'h02;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic is_protected(input logic [ADDR_W-1:0] addr);
      return (addr <= 8'h03) || (addr >= 8'h08 && addr <= 8'h0C) || (addr == 8'h0E) ||
             (addr >= 8'h10 && addr <= 8'h4E);
   endfunction

   function automatic rsp_type map_rsp(input logic [19:0] base, input logic [17:0] size,
                                       input logic rd_int, input logic wr_int);
      rsp_type r;
      r                = '0;
      r.map_valid      = 1'b1;
      r.map_base       = base;
      r.map_size       = size;
      r.read_internal  = rd_int;
      r.write_internal = wr_int;
      return r;
   endfunction

endpackage

// ===== hdl/hbcs_cfg_mem.sv =====
`timescale 1ns / 1ps
// Configuration byte memory: 256 x 8 synchronous RAM with per-entry valid bits.
// Unwritten entries read as their power-on value. Depends on hbcs_pkg.
module hbcs_cfg_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [hbcs_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                   rd_data,
   input  hbcs_pkg::wr_type             wr
);

   logic [7:0]                      mem_ff [hbcs_pkg::CONFIG_DEPTH];
   logic [hbcs_pkg::CONFIG_DEPTH-1:0] valid_ff;
   logic [7:0]                      rd_data_ff;
   logic                            rd_valid_ff;
   logic [hbcs_pkg::ADDR_W-1:0]     rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (wr.clr_smram) begin
            valid_ff[hbcs_pkg::ADDR_SMRAM] <= 1'b0;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : hbcs_pkg::reset_value(rd_addr_ff);

endmodule

// ===== hdl/hbcs_exec.sv =====
`timescale 1ns / 1ps
// Execute stage: forwards the last write, applies the register rules and builds
// up to two response words per access. Depends on hbcs_pkg.
module hbcs_exec (
   input  hbcs_pkg::opcode_type         op,
   input  logic [2:0]                   func_num,
   input  logic [hbcs_pkg::ADDR_W-1:0]  addr,
   input  logic [7:0]                   wdata,
   input  logic [7:0]                   mem_data,
   input  hbcs_pkg::wr_type             fwd,
   input  logic [7:0]                   port,
   output hbcs_pkg::wr_type             wr,
   output hbcs_pkg::rsp_type            rsp0,
   output hbcs_pkg::rsp_type            rsp1,
   output logic                         two
);

   logic [7:0]        old;
   logic [7:0]        v;
   logic [7:0]        chg;
   logic [2:0]        pam_idx;
   logic [19:0]       pam_base;
   logic              ev_a;
   logic              ev_b;
   hbcs_pkg::rsp_type map_a;
   hbcs_pkg::rsp_type map_b;

   always_comb begin
      if (fwd.en && fwd.addr == addr) begin
         old = fwd.data;
      end else if (fwd.clr_smram && addr == hbcs_pkg::ADDR_SMRAM) begin
         old = 8'h00;
      end else begin
         old = mem_data;
      end
   end

   always_comb begin
      v        = wdata;
      ev_a     = 1'b0;
      ev_b     = 1'b0;
      map_a    = '0;
      map_b    = '0;
      pam_idx  = 3'(addr - hbcs_pkg::ADDR_PAM1);
      pam_base = hbcs_pkg::BASE_PAM1 + {2'b00, pam_idx, 15'b0};
      priority if (addr == hbcs_pkg::ADDR_CMD_LO) begin
         v = (wdata & 8'h42) | 8'h04;
      end else if (addr == hbcs_pkg::ADDR_CMD_HI) begin
         v = wdata & 8'h01;
      end else if (addr == hbcs_pkg::ADDR_STS_LO) begin
         v = 8'h00;
      end else if (addr == hbcs_pkg::ADDR_STS_HI) begin
         v = 8'h02;
      end else if (addr == hbcs_pkg::ADDR_PAM0) begin
         ev_a  = (old[7:4] != wdata[7:4]);
         map_a = hbcs_pkg::map_rsp(hbcs_pkg::BASE_PAM0, hbcs_pkg::SIZE_PAM0,
                                   wdata[4], wdata[5]);
      end else if (addr >= hbcs_pkg::ADDR_PAM1 && addr <= hbcs_pkg::ADDR_PAM6) begin
         ev_a  = (old[3:0] != wdata[3:0]);
         ev_b  = (old[7:4] != wdata[7:4]);
         map_a = hbcs_pkg::map_rsp(pam_base, hbcs_pkg::SIZE_PAM, wdata[0], wdata[1]);
         map_b = hbcs_pkg::map_rsp(pam_base + hbcs_pkg::PAM_HALF, hbcs_pkg::SIZE_PAM,
                                   wdata[4], wdata[5]);
      end else if (addr == hbcs_pkg::ADDR_SMRAM) begin
         v = (wdata & 8'h38) | 8'h02 | (old & 8'h08);
         if (v[3]) begin
            v[5] = 1'b0;
         end
         ev_a  = (old[5] != v[5]);
         map_a = hbcs_pkg::map_rsp(hbcs_pkg::BASE_SMRAM, hbcs_pkg::SIZE_SMRAM, v[5], v[5]);
      end else begin
         v = wdata;
      end
   end

   always_comb begin
      chg  = old ^ hbcs_pkg::PAM0_HARD_RESET;
      wr   = '0;
      rsp0 = '0;
      rsp1 = '0;
      two  = 1'b0;
      unique case (op)
         hbcs_pkg::OP_CFG_RD: begin
            rsp0.rdata = (func_num != 3'd0) ? 8'hFF : old;
         end
         hbcs_pkg::OP_CFG_WR: begin
            if (func_num == 3'd0 && !hbcs_pkg::is_protected(addr)) begin
               wr.en   = 1'b1;
               wr.addr = addr;
               wr.data = v;
               if (ev_a && ev_b) begin
                  rsp0 = map_a;
                  rsp1 = map_b;
                  two  = 1'b1;
               end else if (ev_a) begin
                  rsp0 = map_a;
               end else if (ev_b) begin
                  rsp0 = map_b;
               end
            end
         end
         hbcs_pkg::OP_PORT_RD: begin
            rsp0.rdata = port;
         end
         hbcs_pkg::OP_PORT_WR: begin
            if (wdata[2] && !port[2]) begin
               if (wdata[1]) begin
                  wr.en        = 1'b1;
                  wr.addr      = hbcs_pkg::ADDR_PAM0;
                  wr.data      = hbcs_pkg::PAM0_HARD_RESET;
                  wr.clr_smram = 1'b1;
                  if (chg[7:4] != 4'h0) begin
                     rsp0 = hbcs_pkg::map_rsp(hbcs_pkg::BASE_PAM0, hbcs_pkg::SIZE_PAM0,
                                              1'b0, 1'b0);
                     rsp1.reset_kind = hbcs_pkg::RST_HARD;
                     two  = 1'b1;
                  end else begin
                     rsp0.reset_kind = hbcs_pkg::RST_HARD;
                  end
               end else begin
                  rsp0.reset_kind = hbcs_pkg::RST_SOFT;
               end
            end
         end
         default: begin
            rsp0 = '0;
         end
      endcase
      rsp0.last = !two;
      rsp1.last = 1'b1;
   end

endmodule

// ===== hdl/hbcs_rsp_fifo.sv =====
`timescale 1ns / 1ps
// Four-word response queue: takes one or two words per cycle, drives one word per cycle while out_ready is high.
// Depends on hbcs_pkg.
module hbcs_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              push_two,
   input  hbcs_pkg::rsp_type wr0,
   input  hbcs_pkg::rsp_type wr1,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output hbcs_pkg::rsp_type out_word
);

   localparam int DEPTH = 4;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hbcs_pkg::rsp_type ent_ff [DEPTH];
   logic [IDX_W-1:0]  head_ff;
   logic [IDX_W-1:0]  head_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  tail0;
   logic [IDX_W-1:0]  tail1;
   logic              pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_word  = ent_ff[head_ff];
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign tail0     = head_ff + count_ff[IDX_W-1:0];
   assign tail1     = tail0 + IDX_W'(1);

   always_comb begin
      head_in  = pop ? head_ff + IDX_W'(1) : head_ff;
      count_in = count_ff + CNT_W'(push) + CNT_W'(push && push_two) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[tail0] <= wr0;
         if (push_two) begin
            ent_ff[tail1] <= wr1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/host_bridge_config_space.sv =====
`timescale 1ns / 1ps
// Host bridge configuration space with reset-control port: top level.
// Uses hbcs_pkg, hbcs_cfg_mem, hbcs_exec and hbcs_rsp_fifo.
//
// Request channel (req_*): one access word per handshake - config read or write,
// reset port read or write. Response channel (rsp_*): one or two words per access,
// rsp_last marks the final word of an access.
// Response path: an accepted access is registered into the execute stage, and its
// response words are written into the response queue when it advances from there.
// Throughput: one access per cycle while each access gives one word and the
// receiver takes a word every cycle; the single response port (one word per cycle)
// makes a stream of accesses that give two words stall once the queue fills.
// The configuration bytes sit in a 256 x 8 RAM read at accept and written when the
// access leaves the execute stage; a write is forwarded to the access read in the same cycle.
// Reset: all bytes read as their power-on values at once (per-byte valid bits),
// the reset port clears to zero and the response queue empties; no clearing pass.
// Receiver stall: words wait in a four-word queue; the execute stage holds its
// access until two slots are free, and req_ready drops while it holds.
module host_bridge_config_space (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_func_num,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_map_valid,
   output logic [19:0] rsp_map_base,
   output logic [17:0] rsp_map_size,
   output logic        rsp_read_internal,
   output logic        rsp_write_internal,
   output logic [1:0]  rsp_reset_kind,
   output logic        rsp_last
);

   logic                        accept;
   logic                        s1_adv;
   logic                        room;
   logic [hbcs_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                  mem_data;

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   hbcs_pkg::opcode_type        s1_op_ff;
   logic [2:0]                  s1_func_ff;
   logic [hbcs_pkg::ADDR_W-1:0] s1_addr_ff;
   logic [7:0]                  s1_wdata_ff;
   logic [7:0]                  port_ff;
   logic [7:0]                  port_in;
   hbcs_pkg::wr_type            fwd_ff;
   hbcs_pkg::wr_type            fwd_in;

   hbcs_pkg::wr_type            exec_wr;
   hbcs_pkg::wr_type            commit_wr;
   hbcs_pkg::rsp_type           rsp0;
   hbcs_pkg::rsp_type           rsp1;
   logic                        two;
   hbcs_pkg::rsp_type           out_word;

   assign s1_adv    = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign rd_addr   = (hbcs_pkg::opcode_type'(req_opcode) == hbcs_pkg::OP_PORT_WR) ?
                      hbcs_pkg::ADDR_PAM0 : req_reg_addr;

   always_comb begin
      commit_wr = exec_wr;
      if (!s1_adv) begin
         commit_wr = '0;
      end
   end

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      fwd_in      = accept ? commit_wr : fwd_ff;
      port_in     = (s1_adv && s1_op_ff == hbcs_pkg::OP_PORT_WR) ? s1_wdata_ff : port_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         port_ff     <= 8'h00;
         fwd_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         port_ff     <= port_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= hbcs_pkg::opcode_type'(req_opcode);
         s1_func_ff  <= req_func_num;
         s1_addr_ff  <= rd_addr;
         s1_wdata_ff <= req_wdata;
      end
   end

   hbcs_cfg_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (mem_data),
      .wr      (commit_wr)
   );

   hbcs_exec u_exec (
      .op       (s1_op_ff),
      .func_num (s1_func_ff),
      .addr     (s1_addr_ff),
      .wdata    (s1_wdata_ff),
      .mem_data (mem_data),
      .fwd      (fwd_ff),
      .port     (port_ff),
      .wr       (exec_wr),
      .rsp0     (rsp0),
      .rsp1     (rsp1),
      .two      (two)
   );

   hbcs_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_adv),
      .push_two  (two),
      .wr0       (rsp0),
      .wr1       (rsp1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_rdata          = out_word.rdata;
   assign rsp_map_valid      = out_word.map_valid;
   assign rsp_map_base       = out_word.map_base;
   assign rsp_map_size       = out_word.map_size;
   assign rsp_read_internal  = out_word.read_internal;
   assign rsp_write_internal = out_word.write_internal;
   assign rsp_reset_kind     = out_word.reset_kind;
   assign rsp_last           = out_word.last;

endmodule

// ===== hdl/hbcs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the host bridge configuration space, bound to the top level.
// Depends on host_bridge_config_space_macros.svh and hbcs_pkg.
`include "host_bridge_config_space_macros.svh"

module hbcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_rdata,
   input logic        rsp_map_valid,
   input logic [19:0] rsp_map_base,
   input logic [17:0] rsp_map_size,
   input logic [1:0]  rsp_reset_kind,
   input logic        rsp_last
);

   `HBCS_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp after reset")

   `HBCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata) && $stable(rsp_map_base) && $stable(rsp_last), "stalled rsp word changed")

   `HBCS_ASSERT(a_map_word_clean, clock, reset, rsp_valid && rsp_map_valid |-> rsp_rdata == 8'h00 && rsp_reset_kind == hbcs_pkg::RST_NONE, "map word carries data")

   `HBCS_ASSERT(a_no_map_zero, clock, reset, rsp_valid && !rsp_map_valid |-> rsp_map_base == 20'h0 && rsp_map_size == 18'h0, "map fields set without map")

   `HBCS_ASSERT(a_reset_req_last, clock, reset, rsp_valid && rsp_reset_kind != hbcs_pkg::RST_NONE |-> rsp_last && !rsp_map_valid, "reset request not final word")

endmodule

bind host_bridge_config_space hbcs_checker u_checker (.*);
